// ===== hdl/nnrs_pkg.sv =====
// Shared constants, codes and types of the nearest neighbor and radius search unit.
package nnrs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DIMS   = 8;

  localparam int COORD_W = 16;
  localparam int PARAM_W = 20;
  localparam int FUNC_W  = 2;
  localparam int CFG_W   = 4;
  localparam int DIST_W  = 38;
  localparam int SQ_W    = 2 * (COORD_W + 1);
  localparam int R2_W    = 2 * PARAM_W;

  localparam int PT_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int POS_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int ADDR_W = $clog2(MAX_POINTS * MAX_DIMS);

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KNN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RAD  = 2'd2;

  localparam logic [CFG_W-1:0] DIMS_RESET = 4'd8;

  // Distance buffer write from the distance engine to the selector
  typedef struct packed {
    logic              we;
    logic [PT_W-1:0]   addr;
    logic [DIST_W-1:0] data;
  } dist_wr_t;

endpackage

// ===== hdl/nearest_neighbor_and_radius_search_unit.sv =====
// Top level of the nearest neighbor and radius search unit.
// Brute-force point search. A load transaction stores one coordinate; a point is
// complete after dims_in_use coordinates. A query vector also arrives one
// coordinate per transaction; the transaction carrying its last coordinate starts
// the search, and no input is taken until the answer has been handed out. The
// search runs a distance pass over the n stored points and d dimensions (one
// point-store read per cycle), then a k-nearest ranking of every point against
// every point or a radius test of each point (two distance-buffer reads per
// cycle), then scans the answer out in ascending index order, one stored point
// per cycle while the output does not stall.
// An empty answer gives a single result with none_found and last set.
module nearest_neighbor_and_radius_search_unit import nnrs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [COORD_W-1:0] coordinate,
  input  logic [PARAM_W-1:0]        query_param,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PT_W-1:0]           point_index,
  output logic                      none_found,
  output logic                      last,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIST = 4'b0010,
    ST_SEL  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                  state;
  logic [CFG_W-1:0]        dims_in_use;
  logic [DCNT_W-1:0]       dims_act;
  logic [CNT_W-1:0]        count;
  logic [POS_W-1:0]        pos;
  logic                    is_k;
  logic [PARAM_W-1:0]      k;
  logic [R2_W-1:0]         r2;
  logic [MAX_POINTS-1:0]   pick;
  logic [MAX_POINTS-1:0]   pick_left;
  logic [MAX_POINTS-1:0]   rest;
  logic [PT_W-1:0]         eidx;

  logic                    acc;
  logic                    is_load;
  logic                    is_q;
  logic                    vec_done;
  logic                    ld_we;
  logic                    q_we;
  logic                    q_fire;
  logic                    dist_start;
  logic                    dist_done;
  logic                    sel_start;
  logic                    sel_done;
  logic                    slot_free;
  logic                    emit_none;
  logic                    emit_hit;
  logic [ADDR_W-1:0]       ld_addr;
  dist_wr_t                dwr;

  // Clamp the dimension register to the supported range
  always_comb begin
    if (dims_in_use == '0) begin
      dims_act = DCNT_W'(1);
    end else if (int'(dims_in_use) > MAX_DIMS) begin
      dims_act = DCNT_W'(MAX_DIMS);
    end else begin
      dims_act = DCNT_W'(dims_in_use);
    end
  end

  assign in_ready   = state == ST_IDLE;
  assign acc        = in_valid && in_ready;
  assign is_load    = func == FUNC_LOAD;
  assign is_q       = (func == FUNC_KNN) || (func == FUNC_RAD);
  assign vec_done   = ((DCNT_W+1)'(pos) + (DCNT_W+1)'(1)) >= (DCNT_W+1)'(dims_act);
  assign ld_we      = acc && is_load && (count < CNT_W'(MAX_POINTS));
  assign q_we       = acc && is_q;
  assign q_fire     = q_we && vec_done;
  assign dist_start = q_fire && (count != '0);
  assign sel_start  = (state == ST_DIST) && dist_done;
  assign ld_addr    = ADDR_W'(count[PT_W-1:0]) * ADDR_W'(MAX_DIMS) + ADDR_W'(pos);
  assign slot_free  = !out_valid || out_ready;
  assign rest       = pick_left & ~(MAX_POINTS'(1) << eidx);
  assign emit_none  = (state == ST_EMIT) && (pick_left == '0) && slot_free;
  assign emit_hit   = (state == ST_EMIT) && pick_left[eidx] && slot_free;

  nnrs_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .ld_we   (ld_we),
    .ld_addr (ld_addr),
    .ld_data (coordinate),
    .q_we    (q_we),
    .q_idx   (pos),
    .q_data  (coordinate),
    .start   (dist_start),
    .n       (count),
    .dims    (dims_act),
    .dwr     (dwr),
    .done    (dist_done)
  );

  nnrs_sel u_sel (
    .clk   (clk),
    .rst   (rst),
    .dwr   (dwr),
    .start (sel_start),
    .n     (count),
    .is_k  (is_k),
    .k     (k),
    .r2    (r2),
    .pick  (pick),
    .done  (sel_done)
  );

  // Control: configuration, loads, query sequencing and answer scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      dims_in_use <= DIMS_RESET;
      count       <= '0;
      pos         <= '0;
      pick_left   <= '0;
      eidx        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        dims_in_use <= cfg_wdata;
      end
      if (ld_we || q_we) begin
        pos <= vec_done ? '0 : pos + POS_W'(1);
      end
      if (ld_we && vec_done) begin
        count <= count + CNT_W'(1);
      end
      if (emit_none || emit_hit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_fire) begin
            eidx  <= '0;
            state <= (count == '0) ? ST_EMIT : ST_DIST;
          end
        end
        ST_DIST: begin
          if (dist_done) begin
            state <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (sel_done) begin
            pick_left <= pick;
            eidx      <= '0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_none) begin
            state <= ST_IDLE;
          end else if (emit_hit) begin
            pick_left <= rest;
            eidx      <= eidx + PT_W'(1);
            if (rest == '0) begin
              state <= ST_IDLE;
            end
          end else if (pick_left != '0 && !pick_left[eidx]) begin
            eidx <= eidx + PT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch query parameters and result payload
  always_ff @(posedge clk) begin
    if (q_fire) begin
      is_k <= func == FUNC_KNN;
      k    <= query_param;
      r2   <= R2_W'(query_param) * R2_W'(query_param);
    end
    if (emit_none) begin
      point_index <= '0;
      none_found  <= 1'b1;
      last        <= 1'b1;
    end else if (emit_hit) begin
      point_index <= eidx;
      none_found  <= 1'b0;
      last        <= rest == '0;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store size");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pick_left == '0))
    else $error("pending selections left when idle");

  a_none_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_found) |-> (last && point_index == '0))
    else $error("empty answer not marked last with zero index");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (emit_hit && !$past(state == ST_SEL)) |=> (point_index == $past(eidx)))
    else $error("emitted index mismatch");
`endif

endmodule

// ===== hdl/nnrs_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module nnrs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/nnrs_dist.sv =====
// Distance engine: point store, query buffer and squared distance pipeline.
module nnrs_dist import nnrs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ld_we,
  input  logic [ADDR_W-1:0]         ld_addr,
  input  logic [COORD_W-1:0]        ld_data,
  input  logic                      q_we,
  input  logic [POS_W-1:0]          q_idx,
  input  logic [COORD_W-1:0]        q_data,
  input  logic                      start,
  input  logic [CNT_W-1:0]          n,
  input  logic [DCNT_W-1:0]         dims,
  output dist_wr_t                  dwr,
  output logic                      done
);

  logic                      running;
  logic                      issue;
  logic [PT_W-1:0]           ip;
  logic [POS_W-1:0]          id;
  logic [ADDR_W-1:0]         raddr;
  logic [COORD_W-1:0]        pt_q;
  logic                      last_d;
  logic                      last_p;

  logic                      s1_v;
  logic [POS_W-1:0]          s1_d;
  logic                      s1_end;
  logic [PT_W-1:0]           s1_p;
  logic                      s2_v;
  logic                      s2_end;
  logic [PT_W-1:0]           s2_p;
  logic [SQ_W-1:0]           sq;
  logic [DIST_W-1:0]         acc;
  logic [DIST_W-1:0]         acc_sum;
  logic signed [COORD_W:0]   diff;

  logic [COORD_W-1:0]        qbuf [MAX_DIMS];

  // Point store
  nnrs_ram #(.DEPTH(MAX_POINTS * MAX_DIMS), .WIDTH(COORD_W)) u_pts (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_addr),
    .wdata (ld_data),
    .raddr (raddr),
    .rdata (pt_q)
  );

  // Hold query coordinates
  always_ff @(posedge clk) begin
    if (q_we) begin
      qbuf[q_idx] <= q_data;
    end
  end

  assign raddr  = ADDR_W'(ip) * ADDR_W'(MAX_DIMS) + ADDR_W'(id);
  assign last_d = DCNT_W'(id) == dims - DCNT_W'(1);
  assign last_p = CNT_W'(ip) == n - CNT_W'(1);
  assign diff   = $signed({qbuf[s1_d][COORD_W-1], qbuf[s1_d]})
                - $signed({pt_q[COORD_W-1], pt_q});
  assign acc_sum = acc + DIST_W'(sq);
  assign done   = running && !issue && !s1_v && !s2_v;

  // Issue point and dimension reads
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      issue   <= 1'b0;
      ip      <= '0;
      id      <= '0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      if (start) begin
        running <= 1'b1;
        issue   <= 1'b1;
        ip      <= '0;
        id      <= '0;
      end else if (issue) begin
        if (last_d) begin
          id <= '0;
          if (last_p) begin
            issue <= 1'b0;
          end else begin
            ip <= ip + PT_W'(1);
          end
        end else begin
          id <= id + POS_W'(1);
        end
      end else if (done) begin
        running <= 1'b0;
      end
    end
  end

  // Square the difference and accumulate per point
  always_ff @(posedge clk) begin
    s1_d   <= id;
    s1_end <= last_d;
    s1_p   <= ip;
    s2_end <= s1_end;
    s2_p   <= s1_p;
    sq     <= SQ_W'(diff * diff);
    if (start) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= s2_end ? '0 : acc_sum;
    end
  end

  assign dwr.we   = s2_v && s2_end;
  assign dwr.addr = s2_p;
  assign dwr.data = acc_sum;

endmodule

// ===== hdl/nnrs_sel.sv =====
// Selector: distance buffer and per-point rank or radius decision.
module nnrs_sel import nnrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dist_wr_t              dwr,
  input  logic                  start,
  input  logic [CNT_W-1:0]      n,
  input  logic                  is_k,
  input  logic [PARAM_W-1:0]    k,
  input  logic [R2_W-1:0]       r2,
  output logic [MAX_POINTS-1:0] pick,
  output logic                  done
);

  logic              running;
  logic              issue;
  logic [PT_W-1:0]   si;
  logic [PT_W-1:0]   sj;
  logic              jend;
  logic              iend;
  logic              t_v;
  logic [PT_W-1:0]   t_i;
  logic [PT_W-1:0]   t_j;
  logic              t_end;
  logic [DIST_W-1:0] da;
  logic [DIST_W-1:0] db;
  logic              better;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;

  // Two copies of the distance buffer give two read ports
  nnrs_ram #(.DEPTH(MAX_POINTS), .WIDTH(DIST_W)) u_dist_a (
    .clk   (clk),
    .we    (dwr.we),
    .waddr (dwr.addr),
    .wdata (dwr.data),
    .raddr (si),
    .rdata (da)
  );

  nnrs_ram #(.DEPTH(MAX_POINTS), .WIDTH(DIST_W)) u_dist_b (
    .clk   (clk),
    .we    (dwr.we),
    .waddr (dwr.addr),
    .wdata (dwr.data),
    .raddr (sj),
    .rdata (db)
  );

  assign jend     = !is_k || (CNT_W'(sj) == n - CNT_W'(1));
  assign iend     = CNT_W'(si) == n - CNT_W'(1);
  assign better   = (db < da) || ((db == da) && (t_j < t_i));
  assign cnt_next = cnt + CNT_W'(better);
  assign done     = running && !issue && !t_v;

  // Walk candidate i against every point j for k-nearest, or test it alone for radius
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      issue   <= 1'b0;
      si      <= '0;
      sj      <= '0;
      t_v     <= 1'b0;
      cnt     <= '0;
      pick    <= '0;
    end else begin
      t_v <= issue;
      if (start) begin
        running <= 1'b1;
        issue   <= 1'b1;
        si      <= '0;
        sj      <= '0;
        cnt     <= '0;
        pick    <= '0;
      end else begin
        if (issue) begin
          if (jend) begin
            sj <= '0;
            if (iend) begin
              issue <= 1'b0;
            end else begin
              si <= si + PT_W'(1);
            end
          end else begin
            sj <= sj + PT_W'(1);
          end
        end else if (done) begin
          running <= 1'b0;
        end
        // Decide on a candidate once its comparisons are in
        if (t_v) begin
          if (t_end) begin
            cnt <= '0;
            pick[t_i] <= is_k ? (PARAM_W'(cnt_next) < k) : (R2_W'(da) <= r2);
          end else begin
            cnt <= cnt_next;
          end
        end
      end
    end
  end

  // Tag the read in flight
  always_ff @(posedge clk) begin
    t_i   <= si;
    t_j   <= sj;
    t_end <= jend;
  end

endmodule
